FILE: rtl/core/wgm_pkg.sv
// Package: function codes, glob constants and cell control type for the glob matcher.
package wgm_pkg;

    typedef enum logic [1:0] {
        FN_CLEAR   = 2'd0,
        FN_APPEND  = 2'd1,
        FN_SUBJECT = 2'd2,
        FN_FINISH  = 2'd3
    } t_func;

    localparam logic [7:0] GLOB_STAR = 8'h2A;  // '*'
    localparam logic [7:0] GLOB_ANY  = 8'h3F;  // '?'

    typedef struct packed {
        logic clear;   // drop the whole pattern
        logic append;  // write pattern byte at the current length (room left)
        logic rearm;   // reload reach bits from the star-only prefix
        logic feed;    // advance reach bits by one subject byte
    } t_cell_ctl;

endpackage

FILE: rtl/core/wgm_cell.sv
// One pattern position: stored byte, valid flag and the reach bit past it.
module wgm_cell
    import wgm_pkg::*;
#(
    parameter int IDX = 0,
    parameter int LW  = 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_ctl       i_ctl,
    input  logic [LW-1:0]   i_len,
    input  logic [7:0]      i_ch,
    input  logic            i_reach_left,
    input  logic            i_chain,
    output logic            o_chain,
    output logic            o_reach,
    output logic            o_active
);

    logic [7:0] r_pat;
    logic [7:0] n_pat;
    logic       r_active;
    logic       n_active;
    logic       r_reach;
    logic       n_reach;
    logic       wr;
    logic       chain_out;

    always_comb begin
        wr       = i_ctl.append && (i_len == LW'(IDX));
        n_pat    = wr ? i_ch : r_pat;
        n_active = i_ctl.clear ? 1'b0 : (wr ? 1'b1 : r_active);
        if (i_ctl.rearm) begin
            // leading run of stars is reachable with an empty subject
            chain_out = n_active && (n_pat == GLOB_STAR) && i_chain;
        end else if (r_pat == GLOB_STAR) begin
            chain_out = r_active && (r_reach || i_chain);
        end else begin
            chain_out = r_active && i_reach_left
                        && ((r_pat == i_ch) || (r_pat == GLOB_ANY));
        end
        n_reach = (i_ctl.rearm || i_ctl.feed) ? chain_out : r_reach;
    end

    always_ff @(posedge i_clk) begin
        r_pat <= n_pat;
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_reach  <= 1'b0;
        end else begin
            r_active <= n_active;
            r_reach  <= n_reach;
        end
    end

    assign o_chain  = chain_out;
    assign o_reach  = r_reach;
    assign o_active = r_active;

endmodule

FILE: rtl/core/wildcard_glob_matcher.sv
// Glob matcher top level: '?' and '*' pattern against a streamed subject, one cell per pattern byte.
// Takes one transaction per cycle of any kind (clear, append, subject byte, finish); a finish
// transaction's result is registered and shows on the output the next cycle. That rate rests on
// the row of MAX_PATTERN cells, which updates every reach bit at once through a combinational ripple
// of star closure running from cell to cell. The input stalls only while a result waits and the
// output side stalls. A pattern past MAX_PATTERN bytes reports overflow and no match until cleared.
module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_ch,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_matched,
    output logic       o_overflow
);

    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic                   acc;
    t_func                  func;
    t_cell_ctl              ctl;
    logic                   room;
    logic [LW-1:0]          r_len;
    logic [LW-1:0]          n_len;
    logic                   r_too_long;
    logic                   n_too_long;
    logic                   r_reach0;
    logic                   n_reach0;
    logic [MAX_PATTERN-1:0] reach_vec;
    logic [MAX_PATTERN-1:0] active_vec;
    logic [MAX_PATTERN-1:0] last_vec;
    logic [MAX_PATTERN:0]   chain;
    logic                   hit;
    logic                   r_out_valid;
    logic                   r_matched;
    logic                   r_overflow;

    assign o_stall = r_out_valid && i_stall;
    assign acc     = i_valid && !o_stall;
    assign func    = t_func'(i_func);
    assign room    = r_len < LW'(MAX_PATTERN);

    always_comb begin
        ctl.clear  = acc && (func == FN_CLEAR);
        ctl.append = acc && (func == FN_APPEND) && room;
        ctl.rearm  = acc && (func != FN_SUBJECT);
        ctl.feed   = acc && (func == FN_SUBJECT);
    end

    // rearm seeds position zero; a subject byte never reaches it
    assign chain[0] = ctl.rearm;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic left;
        if (k == 0) begin : g_first
            assign left = r_reach0;
        end else begin : g_rest
            assign left = reach_vec[k-1];
        end
        if (k == MAX_PATTERN - 1) begin : g_tail
            assign last_vec[k] = active_vec[k];
        end else begin : g_mid
            assign last_vec[k] = active_vec[k] && !active_vec[k+1];
        end

        wgm_cell #(
            .IDX (k),
            .LW  (LW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_len        (r_len),
            .i_ch         (i_ch),
            .i_reach_left (left),
            .i_chain      (chain[k]),
            .o_chain      (chain[k+1]),
            .o_reach      (reach_vec[k]),
            .o_active     (active_vec[k])
        );
    end

    always_comb begin
        n_len      = r_len;
        n_too_long = r_too_long;
        n_reach0   = r_reach0;
        if (ctl.clear) begin
            n_len      = '0;
            n_too_long = 1'b0;
        end else if (ctl.append) begin
            n_len = r_len + LW'(1);
        end else if (acc && (func == FN_APPEND)) begin
            n_too_long = 1'b1;
        end
        if (ctl.rearm) begin
            n_reach0 = 1'b1;
        end else if (ctl.feed) begin
            n_reach0 = 1'b0;
        end
        // reach bit at the pattern end; empty pattern uses position zero
        hit = (r_len == '0) ? r_reach0 : |(reach_vec & last_vec);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_too_long  <= 1'b0;
            r_reach0    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_too_long <= n_too_long;
            r_reach0   <= n_reach0;
            if (acc && (func == FN_FINISH)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && (func == FN_FINISH)) begin
            r_matched  <= hit && !r_too_long;
            r_overflow <= r_too_long;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_matched  = r_matched;
    assign o_overflow = r_overflow;

endmodule

FILE: rtl/core/wgm_checker.sv
// Port-level checker for the glob matcher, bound to the top level.
module wgm_checker
    import wgm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_func,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_matched,
    input logic       o_overflow
);

    logic in_acc;
    logic fin_acc;
    logic clr_acc;

    assign in_acc  = i_valid && !o_stall;
    assign fin_acc = in_acc && (i_func == FN_FINISH);
    assign clr_acc = in_acc && (i_func == FN_CLEAR);

    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_matched) && $stable(o_overflow))
        else $error("result changed while stalled");

    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_acc |=> o_valid)
        else $error("finish transaction gave no result");

    a_only_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(fin_acc))
        else $error("result without finish transaction");

    a_overflow_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> !o_matched)
        else $error("match reported with overflowed pattern");

    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_acc ##1 fin_acc |=> o_valid && o_matched && !o_overflow)
        else $error("empty subject against empty pattern must match");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (.*);

FILE: dv/tb_wildcard_glob_matcher.sv
// Self-checking testbench for wildcard_glob_matcher against a reach-bit predictor.
`timescale 1ns / 1ps

module tb_wildcard_glob_matcher;
    import wgm_pkg::*;

    localparam int MAX_PAT    = 64;
    localparam int RAND_ITEMS = 1300;
    localparam int HOLD_LEN   = 150;
    localparam int TAIL_CYC   = 20;
    localparam int CYCLE_CAP  = 400000;
    localparam int PRINT_CAP  = 40;

    typedef struct packed {
        t_func      func;
        logic [7:0] ch;
    } t_glob_op;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_glob_verdict;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [1:0] i_func = FN_CLEAR;
    logic [7:0] i_ch = 8'h00;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_matched;
    logic       o_overflow;

    wildcard_glob_matcher #(.MAX_PATTERN(MAX_PAT)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_func     (i_func),
        .i_ch       (i_ch),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_matched  (o_matched),
        .o_overflow (o_overflow)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // pending stimulus and expected verdicts
    t_glob_op      op_q[$];
    t_glob_verdict verdict_q[$];
    int            n_gen = -1;
    int            n_acc = 0;
    int            n_err = 0;
    int            n_finish = 0;
    int            n_hit = 0;
    int            n_ovf = 0;
    int            n_subj = 0;
    int            cyc = 0;
    bit            took_op = 1'b0;

    // predictor state
    logic [7:0]       pat_mem [MAX_PAT];
    int unsigned      pat_cnt = 0;
    logic [MAX_PAT:0] reach = {{MAX_PAT{1'b0}}, 1'b1};
    logic             too_long = 1'b0;

    function automatic void reload_reach();
        reach    = '0;
        reach[0] = 1'b1;
        for (int k = 0; k < pat_cnt; k++)
            reach[k+1] = reach[k] && (pat_mem[k] == GLOB_STAR);
    endfunction

    function automatic void advance_reach(logic [7:0] c);
        logic [MAX_PAT:0] nxt;
        nxt = '0;
        for (int k = 0; k < pat_cnt; k++) begin
            if (pat_mem[k] == GLOB_STAR)
                nxt[k+1] = reach[k+1] || nxt[k];
            else
                nxt[k+1] = reach[k] && (pat_mem[k] == c || pat_mem[k] == GLOB_ANY);
        end
        reach = nxt;
    endfunction

    function automatic void predict_glob(t_func f, logic [7:0] c);
        t_glob_verdict v;
        case (f)
            FN_CLEAR: begin
                pat_cnt  = 0;
                too_long = 1'b0;
                reload_reach();
            end
            FN_APPEND: begin
                if (pat_cnt < MAX_PAT) begin
                    pat_mem[pat_cnt] = c;
                    pat_cnt++;
                end else begin
                    too_long = 1'b1;
                end
                reload_reach();
            end
            FN_SUBJECT: begin
                advance_reach(c);
                n_subj++;
            end
            default: begin
                v.matched  = reach[pat_cnt] && !too_long;
                v.overflow = too_long;
                verdict_q.push_back(v);
                n_finish++;
                if (v.matched) n_hit++;
                if (v.overflow) n_ovf++;
                reload_reach();
            end
        endcase
    endfunction

    // stimulus generation
    logic [7:0] gen_pat[$];
    bit         need_clear = 1'b1;

    task automatic push_op(t_func f, logic [7:0] c);
        t_glob_op op;
        op.func = f;
        op.ch   = c;
        op_q.push_back(op);
    endtask

    function automatic logic [7:0] pick_pat_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return GLOB_STAR;
        if (r < 5) return GLOB_ANY;
        if (r < 8) return 8'h61 + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_subj_byte();
        int r;
        r = $urandom_range(0, 3);
        if (r < 3) return 8'h61 + 8'(r);
        return 8'($urandom_range(0, 255));
    endfunction

    // subject that fits the held pattern, then maybe damaged; or a random subject when fit is clear
    task automatic push_subject(bit fit);
        logic [7:0] subj[$];
        int         held;
        int         pos;
        int         r;
        held = (gen_pat.size() < MAX_PAT) ? gen_pat.size() : MAX_PAT;
        if (fit) begin
            for (int k = 0; k < held; k++) begin
                if (gen_pat[k] == GLOB_STAR)
                    repeat ($urandom_range(0, 3)) subj.push_back(pick_subj_byte());
                else if (gen_pat[k] == GLOB_ANY)
                    subj.push_back(8'($urandom_range(0, 255)));
                else
                    subj.push_back(gen_pat[k]);
            end
            r = $urandom_range(0, 5);
            if (r == 0 && subj.size() > 0) begin
                pos = $urandom_range(0, subj.size() - 1);
                subj[pos] = pick_subj_byte();
            end else if (r == 1 && subj.size() > 0) begin
                subj.delete($urandom_range(0, subj.size() - 1));
            end else if (r == 2) begin
                subj.insert($urandom_range(0, subj.size()), pick_subj_byte());
            end
        end else begin
            repeat ($urandom_range(0, 6)) subj.push_back(pick_subj_byte());
        end
        foreach (subj[k]) push_op(FN_SUBJECT, subj[k]);
        push_op(FN_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_pattern(int len);
        logic [7:0] b;
        if (need_clear || $urandom_range(0, 9) != 0) begin
            push_op(FN_CLEAR, 8'($urandom_range(0, 255)));
            gen_pat.delete();
            need_clear = 1'b0;
        end
        repeat (len) begin
            b = pick_pat_byte();
            gen_pat.push_back(b);
            push_op(FN_APPEND, b);
        end
    endtask

    task automatic build_stimulus();
        int r;
        // empty pattern, empty and non-empty subject
        push_op(FN_FINISH, 8'h00);
        push_op(FN_SUBJECT, 8'h00);
        push_op(FN_FINISH, 8'hFF);
        // stars only: empty subject and one byte both match
        push_op(FN_APPEND, GLOB_STAR);
        push_op(FN_APPEND, GLOB_STAR);
        push_op(FN_FINISH, 8'h00);
        push_op(FN_SUBJECT, 8'hFF);
        push_op(FN_FINISH, 8'h00);
        // literal extremes, any-byte and trailing star
        push_op(FN_CLEAR, 8'hFF);
        push_op(FN_APPEND, 8'h00);
        push_op(FN_APPEND, GLOB_ANY);
        push_op(FN_APPEND, 8'hFF);
        push_op(FN_APPEND, GLOB_STAR);
        push_op(FN_SUBJECT, 8'h00);
        push_op(FN_SUBJECT, 8'h55);
        push_op(FN_SUBJECT, 8'hFF);
        push_op(FN_SUBJECT, 8'hAA);
        push_op(FN_FINISH, 8'h00);
        // pattern edited mid-subject restarts the subject
        push_op(FN_SUBJECT, 8'h00);
        push_op(FN_APPEND, GLOB_ANY);
        push_op(FN_SUBJECT, 8'h00);
        push_op(FN_FINISH, 8'h00);
        push_op(FN_SUBJECT, 8'h7F);
        push_op(FN_CLEAR, 8'h00);
        push_op(FN_FINISH, 8'h00);
        need_clear = 1'b1;

        // one overflowed pattern up front, then a mix
        push_pattern(MAX_PAT + 2);
        repeat (3) push_subject($urandom_range(0, 1));
        while (op_q.size() < RAND_ITEMS) begin
            r = $urandom_range(0, 19);
            if (r < 16) begin
                if ($urandom_range(0, 11) == 0)
                    push_pattern($urandom_range(MAX_PAT - 4, MAX_PAT + 4));
                else
                    push_pattern($urandom_range(0, 8));
                repeat ($urandom_range(1, 6)) push_subject($urandom_range(0, 3) != 0);
            end else if (r < 18) begin
                // broken: pattern change mid-subject
                push_pattern($urandom_range(1, 5));
                repeat ($urandom_range(1, 3)) push_op(FN_SUBJECT, pick_subj_byte());
                if ($urandom_range(0, 1)) begin
                    gen_pat.delete();
                    push_op(FN_CLEAR, 8'($urandom_range(0, 255)));
                end else begin
                    gen_pat.push_back(GLOB_ANY);
                    push_op(FN_APPEND, GLOB_ANY);
                end
                push_subject(1'b1);
            end else begin
                repeat ($urandom_range(1, 10))
                    push_op(t_func'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                need_clear = 1'b1;
            end
        end
    endtask

    // sender: bursts of transactions with random gaps
    int       burst_left = 0;
    int       gap_left = 0;
    t_glob_op cur_op;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || took_op) begin
            if (gap_left > 0 || op_q.size() == 0) begin
                i_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                cur_op = op_q.pop_front();
                i_valid <= 1'b1;
                i_func  <= cur_op.func;
                i_ch    <= cur_op.ch;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // receiver: changing stall patterns plus two long hold-offs
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;
    int       hold_left = 0;
    int       hold_idx = 0;
    int       hold_at[2] = '{300, 900};

    always @(negedge i_clk) begin
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_idx < 2 && n_acc >= hold_at[hold_idx]) begin
            hold_idx++;
            hold_left = HOLD_LEN - 1;
            i_stall <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 120);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:  i_stall <= 1'b0;
                RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default:  i_stall <= ((rx_tick % 5) >= 3);
            endcase
        end
    end

    // input acceptance feeds the predictor; output acceptance is checked
    t_glob_verdict want;

    always @(posedge i_clk) begin
        cyc++;
        took_op = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                took_op = 1'b1;
                n_acc++;
                predict_glob(t_func'(i_func), i_ch);
            end
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    n_err++;
                    if (n_err <= PRINT_CAP)
                        $display("%0t: unexpected result matched=%0b overflow=%0b",
                                 $time, o_matched, o_overflow);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_matched !== want.matched) begin
                        n_err++;
                        if (n_err <= PRINT_CAP)
                            $display("%0t: matched expected %0b actual %0b",
                                     $time, want.matched, o_matched);
                    end
                    if (o_overflow !== want.overflow) begin
                        n_err++;
                        if (n_err <= PRINT_CAP)
                            $display("%0t: overflow expected %0b actual %0b",
                                     $time, want.overflow, o_overflow);
                    end
                end
            end
        end
        if (cyc > CYCLE_CAP) begin
            $display("%0t: timeout, %0d of %0d transactions taken, %0d results pending",
                     $time, n_acc, n_gen, verdict_q.size());
            $display("wildcard_glob_matcher regression: fail");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        n_gen = op_q.size();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (n_acc == n_gen && verdict_q.size() == 0);
        repeat (TAIL_CYC) @(posedge i_clk);
        #1;
        if (verdict_q.size() != 0) begin
            n_err++;
            $display("%0t: %0d expected results never arrived", $time, verdict_q.size());
        end
        $display("covered %0d transactions: %0d subject bytes, %0d finishes", n_acc, n_subj,
                 n_finish);
        $display("  %0d matches, %0d overflow verdicts, %0d errors", n_hit, n_ovf, n_err);
        if (n_err == 0) begin
            $display("wildcard_glob_matcher regression: pass");
        end else begin
            $display("wildcard_glob_matcher regression: fail");
        end
        $finish;
    end

endmodule
